@@ rtl/lbs_pkg.sv @@
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int BONE_COUNT = 256;
  localparam int INFLUENCES = 4;
  localparam int ROW_ELEMS  = 12;
  localparam int IDX_BITS   = 8;
  localparam logic [7:0] IDX_MASK = 8'hFF;

  // Widths of the lane datapath.
  localparam int T_W      = 50;  // affine row result, |t| < 2^48
  localparam int CONTRIB_W = 53; // weighted contribution of one bone
  localparam int SUM_W    = 55;  // sum of four contributions

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SKIN  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [7:0]         bone_slot;
    logic [3:0]         element_slot;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        bone_indices;
    logic [16:0]        weight_a;
    logic [16:0]        weight_b;
    logic [16:0]        weight_c;
    logic [16:0]        weight_d;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] skinned_z;
  } lbs_out_t;

  // Matrix element write, broadcast to every lane's copy of the bone table.
  typedef struct packed {
    logic        en;
    logic [7:0]  bone;
    logic [3:0]  elem;
    logic [31:0] value;
  } lbs_wr_t;

  // Per-stage advance enables.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lbs_adv_t;

endpackage

@@ rtl/lbs_lane.sv @@
`timescale 1ns / 1ps
// One bone influence: private copy of the bone table, the 3x4 affine
// transform and the weighting, four register stages after the table read.
module lbs_lane
  import lbs_pkg::*;
(
  input  logic                        clk,
  input  lbs_wr_t                     wr,
  input  lbs_adv_t                    adv,
  input  logic [7:0]                  rd_bone,
  input  logic [16:0]                 weight,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  output logic signed [CONTRIB_W-1:0] contrib [3]
);

  logic [ROW_ELEMS-1:0][31:0] mem [BONE_COUNT];
  logic [ROW_ELEMS-1:0][31:0] row;
  logic [16:0]                w1, w2, w3;
  logic signed [63:0]         prod [3][3];
  logic signed [31:0]         offs [3];
  logic signed [T_W-1:0]      t [3];
  logic signed [51:0]         hw [3];
  logic [32:0]                lw [3];
  logic signed [31:0]         pos [3];

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // Table write and registered row read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bone][wr.elem] <= wr.value;
    end
    if (adv.s1) begin
      row <= mem[rd_bone];
      w1  <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(row[r*4+c]) * pos[c];
        end
        offs[r] <= $signed(row[r*4+3]);
      end
      w2 <= w1;
    end
    if (adv.s3) begin
      for (int r = 0; r < 3; r++) begin
        t[r] <= T_W'($signed(prod[r][0][63:16])) + T_W'($signed(prod[r][1][63:16]))
              + T_W'($signed(prod[r][2][63:16])) + T_W'(offs[r]);
      end
      w3 <= w2;
    end
    if (adv.s4) begin
      // Exact floor(t*w/2^16) split into a signed high part and the low 16 bits.
      for (int r = 0; r < 3; r++) begin
        hw[r] <= $signed(t[r][T_W-1:16]) * $signed({1'b0, w3});
        lw[r] <= t[r][15:0] * w3;
      end
    end
    if (adv.s5) begin
      for (int r = 0; r < 3; r++) begin
        contrib[r] <= CONTRIB_W'(hw[r]) + CONTRIB_W'({1'b0, lw[r][32:16]});
      end
    end
  end

endmodule

@@ rtl/linear_blend_skinning_core.sv @@
`timescale 1ns / 1ps
// Channel  | Signals                                  | Item
// vertex   | vertex_valid, vertex_ready, vertex       | matrix write or vertex
// result   | result_valid, result_ready, result       | skinned position
//
// One item is accepted per cycle while vertex_ready is high. A vertex passes
// through the table read at the accepting edge, then multiply, row sum,
// weight multiply, weight add, and the sum of the four influences into the
// output register.
// Reset clears all stage valid bits; the bone table is not cleared and
// reads of never written entries give undefined values.
// Each stage moves when the next one is empty or moving, so a stalled result
// stops the pipeline only once every stage in front of it holds an item.
module linear_blend_skinning_core
  import lbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     vertex_valid,
  output logic     vertex_ready,
  input  lbs_in_t  vertex,
  output logic     result_valid,
  input  logic     result_ready,
  output lbs_out_t result
);

  lbs_adv_t           adv;
  lbs_wr_t            wr;
  logic               v1, v2, v3, v4, v5;
  logic               accept;
  logic               adv_out;
  logic signed [31:0] px, py, pz;
  logic [16:0]        wts [4];
  logic signed [CONTRIB_W-1:0] contrib [4][3];
  logic signed [SUM_W-1:0]     sum [3];
  logic signed [31:0]          sat [3];

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

  // Advance chain from the output register backward.
  assign adv_out      = !result_valid || result_ready;
  assign adv.s5       = !v5 || adv_out;
  assign adv.s4       = !v4 || adv.s5;
  assign adv.s3       = !v3 || adv.s4;
  assign adv.s2       = !v2 || adv.s3;
  assign adv.s1       = !v1 || adv.s2;
  assign vertex_ready = adv.s1;
  assign accept       = vertex_valid && vertex_ready;

  // Writes outside the table or past the last element are dropped.
  assign wr.en    = accept && (vertex.action == ACT_WRITE)
                  && ({1'b0, vertex.bone_slot} < 9'(BONE_COUNT))
                  && (vertex.element_slot < 4'(ROW_ELEMS));
  assign wr.bone  = vertex.bone_slot;
  assign wr.elem  = vertex.element_slot;
  assign wr.value = vertex.element_value;

  assign wts[0] = vertex.weight_a;
  assign wts[1] = vertex.weight_b;
  assign wts[2] = vertex.weight_c;
  assign wts[3] = vertex.weight_d;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0]  idx;
    logic [16:0] w_eff;
    assign idx = vertex.bone_indices[k*IDX_BITS +: IDX_BITS] & IDX_MASK;
    // An influence past the configured count or naming a missing bone adds zero.
    assign w_eff = (k < INFLUENCES && {1'b0, idx} < 9'(BONE_COUNT)) ? wts[k] : '0;
    lbs_lane u_lane (
      .clk     (clk),
      .wr      (wr),
      .adv     (adv),
      .rd_bone (idx),
      .weight  (w_eff),
      .pos_x   (px),
      .pos_y   (py),
      .pos_z   (pz),
      .contrib (contrib[k])
    );
  end

  // Stage valid bits: only vertex items travel down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv.s1) v1 <= accept && (vertex.action == ACT_SKIN);
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv.s4) v4 <= v3;
      if (adv.s5) v5 <= v4;
      if (adv_out) result_valid <= v5;
    end
  end

  // Position is registered with the table row read, for the multiplier stage.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      px <= vertex.pos_x;
      py <= vertex.pos_y;
      pz <= vertex.pos_z;
    end
  end

  // Sum the four weighted contributions and clamp to the Q16.16 range.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(contrib[0][r]) + SUM_W'(contrib[1][r])
             + SUM_W'(contrib[2][r]) + SUM_W'(contrib[3][r]);
      if (sum[r] > SAT_MAX) begin
        sat[r] = 32'sh7FFFFFFF;
      end else if (sum[r] < SAT_MIN) begin
        sat[r] = 32'sh80000000;
      end else begin
        sat[r] = sum[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      result.skinned_x <= sat[0];
      result.skinned_y <= sat[1];
      result.skinned_z <= sat[2];
    end
  end

  // An empty output register never holds off the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> vertex_ready) else $error("input stalled with empty output");

  // A finished item in the last lane stage reaches the output register.
  a_last_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (v5 && adv_out) |=> result_valid) else $error("result lost at output stage");

  // Matrix writes never enter the pipeline as items.
  a_write_no_item: assert property (@(posedge clk) disable iff (rst)
    (accept && vertex.action == ACT_WRITE) |=> !v1) else $error("write item made a result");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid) else $error("result pending after reset");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import lbs_pkg::*;

  // Predicts skinned positions from its own copy of the bone table and
  // checks every result of the block against the oldest prediction.
  class skin_scoreboard;
    logic [31:0] bone_table [BONE_COUNT*ROW_ELEMS];
    lbs_out_t    pending_positions[$];
    int          error_count;

    function new();
      error_count = 0;
      foreach (bone_table[i]) bone_table[i] = '0;
    endfunction

    // Floor of m*p in Q16.16.
    function automatic longint scaled_product(logic signed [31:0] m,
                                              logic signed [31:0] p);
      longint prod;
      prod = longint'(m) * longint'(p);
      return prod >>> 16;
    endfunction

    // Floor of t*w / 65536, done exactly in 128 bits.
    function automatic longint weighted(longint t, logic [16:0] w);
      logic signed [127:0] wide;
      wide = 128'(signed'(t)) * $signed({111'd0, w});
      wide = wide >>> 16;
      return longint'(wide);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_item(lbs_in_t it);
      longint acc [3];
      longint t;
      logic [16:0] w [4];
      logic signed [31:0] p [3];
      int bone;
      lbs_out_t predicted;
      if (it.action == ACT_WRITE) begin
        if (it.element_slot < ROW_ELEMS)
          bone_table[it.bone_slot*ROW_ELEMS + it.element_slot] = it.element_value;
        return;
      end
      w = '{it.weight_a, it.weight_b, it.weight_c, it.weight_d};
      p = '{it.pos_x, it.pos_y, it.pos_z};
      acc = '{0, 0, 0};
      for (int k = 0; k < INFLUENCES; k++) begin
        bone = (it.bone_indices >> (k*IDX_BITS)) & IDX_MASK;
        for (int r = 0; r < 3; r++) begin
          t = longint'($signed(bone_table[bone*ROW_ELEMS + r*4 + 3]));
          for (int c = 0; c < 3; c++)
            t += scaled_product(bone_table[bone*ROW_ELEMS + r*4 + c], p[c]);
          acc[r] += weighted(t, w[k]);
        end
      end
      predicted.skinned_x = clamp32(acc[0]);
      predicted.skinned_y = clamp32(acc[1]);
      predicted.skinned_z = clamp32(acc[2]);
      pending_positions = {pending_positions, predicted};
    endfunction

    function void check_result(lbs_out_t got);
      lbs_out_t exp_pos;
      if (pending_positions.size() == 0) begin
        $error("unexpected result %h", got);
        error_count++;
        return;
      end
      exp_pos = pending_positions.pop_front();
      if (got.skinned_x !== exp_pos.skinned_x) begin
        $error("skinned_x expected %h actual %h", exp_pos.skinned_x, got.skinned_x);
        error_count++;
      end
      if (got.skinned_y !== exp_pos.skinned_y) begin
        $error("skinned_y expected %h actual %h", exp_pos.skinned_y, got.skinned_y);
        error_count++;
      end
      if (got.skinned_z !== exp_pos.skinned_z) begin
        $error("skinned_z expected %h actual %h", exp_pos.skinned_z, got.skinned_z);
        error_count++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     vertex_valid = 1'b0;
  logic     vertex_ready;
  lbs_in_t  vertex = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  lbs_out_t result;

  skin_scoreboard board = new();
  bit  calm_phase = 0;
  bit  hold_results = 0;
  int  idle_cycles = 0;

  linear_blend_skinning_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && vertex_valid && vertex_ready) board.note_item(vertex);
    if (!rst && result_valid && result_ready) board.check_result(result);
    if (!rst && !(vertex_valid && vertex_ready) && !(result_valid && result_ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= 5000) begin
      $display("** linear_blend_skinning_core: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, none in the calm phase or while held.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        @(negedge clk);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Valid stays high between items unless an idle burst comes first.
  task automatic send_item(lbs_in_t it);
    if (!calm_phase && $urandom_range(0, 6) == 0) begin
      vertex_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    vertex <= it;
    vertex_valid <= 1'b1;
    @(posedge clk);
    while (!vertex_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_input();
    vertex_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_element(int bone, int elem, logic [31:0] value);
    lbs_in_t it;
    it = '0;
    it.action = ACT_WRITE;
    it.bone_slot = 8'(bone);
    it.element_slot = 4'(elem);
    it.element_value = value;
    it.bone_indices = $urandom;
    it.pos_x = $urandom;
    send_item(it);
  endtask

  // Loads all twelve elements of one bone.
  task automatic load_bone(int bone, bit extreme);
    logic [31:0] v;
    for (int e = 0; e < ROW_ELEMS; e++) begin
      case ($urandom_range(0, 3))
        0: v = extreme ? 32'h8000_0000 : 32'h0001_0000;
        1: v = extreme ? 32'h7FFF_FFFF : $urandom_range(0, 32'h3FFFF) - 32'h20000;
        default: v = extreme ? $urandom : $urandom_range(0, 32'h3FFFF) - 32'h20000;
      endcase
      write_element(bone, e, v);
    end
  endtask

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic skin_vertex(logic [31:0] indices, bit wild);
    lbs_in_t it;
    it = '0;
    it.action = ACT_SKIN;
    it.bone_slot = 8'($urandom);
    it.element_slot = 4'($urandom);
    it.element_value = $urandom;
    it.bone_indices = indices;
    it.pos_x = wild ? $urandom : $urandom_range(0, 32'h7FFFFF) - 32'h400000;
    it.pos_y = wild ? $urandom : $urandom_range(0, 32'h7FFFFF) - 32'h400000;
    it.pos_z = wild ? $urandom : $urandom_range(0, 32'h7FFFFF) - 32'h400000;
    it.weight_a = pick_weight();
    it.weight_b = pick_weight();
    it.weight_c = pick_weight();
    it.weight_d = pick_weight();
    send_item(it);
  endtask

  function automatic logic [31:0] loaded_indices(int loaded);
    logic [31:0] idx;
    for (int k = 0; k < 4; k++)
      idx[k*8 +: 8] = 8'($urandom_range(0, loaded - 1));
    return idx;
  endfunction

  initial begin
    int loaded;
    lbs_in_t it;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: identity bone 0, extreme bone 255, ignored writes.
    for (int e = 0; e < ROW_ELEMS; e++)
      write_element(0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
    load_bone(255, 1);
    write_element(7, 12, 32'hDEAD_BEEF);
    write_element(7, 15, 32'h1234_5678);
    skin_vertex(32'h0, 0);
    skin_vertex(32'hFFFF_FFFF, 1);
    skin_vertex(32'h00FF_00FF, 1);
    it = '0;
    it.action = ACT_SKIN;
    it.pos_x = 32'h7FFF_FFFF; it.pos_y = 32'h8000_0000; it.pos_z = 32'hFFFF_FFFF;
    it.bone_indices = 32'hFFFF_FFFF;
    it.weight_a = 17'h1FFFF; it.weight_b = 17'h1FFFF;
    it.weight_c = 17'h1FFFF; it.weight_d = 17'h1FFFF;
    send_item(it);
    it.bone_indices = 32'h0;
    it.weight_a = 17'd65536; it.weight_b = '0; it.weight_c = '0; it.weight_d = '0;
    send_item(it);
    loaded = 1;

    // Long receiver hold-off while items keep coming so the pipe backs up.
    hold_results = 1;
    fork
      begin
        repeat (60) @(negedge clk);
        hold_results = 0;
      end
      for (int n = 0; n < 20; n++) skin_vertex(loaded_indices(loaded), $urandom_range(0, 3) == 0);
    join

    // Sender pauses until everything has drained.
    idle_input();
    while (board.pending_positions.size() != 0) @(negedge clk);

    // Random part: grow the set of loaded bones, then mostly skin them.
    for (int n = 0; n < 980; n++) begin
      if (n >= 900) calm_phase = 1;
      if (loaded < 40 && $urandom_range(0, 9) == 0) begin
        load_bone(loaded, $urandom_range(0, 4) == 0);
        loaded++;
        n += 11;
      end else if ($urandom_range(0, 12) == 0) begin
        // Overwrite an element of a loaded bone, or an ignored slot.
        write_element($urandom_range(0, loaded - 1), $urandom_range(0, 15), $urandom);
      end else begin
        skin_vertex(loaded_indices(loaded), $urandom_range(0, 4) == 0);
      end
    end

    idle_input();
    while (board.pending_positions.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (board.error_count == 0)
      $display("** linear_blend_skinning_core: PASSED **");
    else
      $display("** linear_blend_skinning_core: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lbs_pkg.sv
rtl/lbs_lane.sv
rtl/linear_blend_skinning_core.sv
test/testbench.sv
